[sv/bma_pkg.sv]
// ----------------------------------------------------------------------------
// bma_pkg
// Types and constants shared by the block map allocator.
// ----------------------------------------------------------------------------
package bma_pkg;

    localparam int BLOCK_BYTES   = 32;
    localparam int MAP_ENTRIES   = 2048;
    localparam int BLOCK_SHIFT   = $clog2(BLOCK_BYTES);
    localparam int MAP_AW        = $clog2(MAP_ENTRIES);
    localparam int ENTRY_W       = 12;
    localparam int ENTRY_MAX     = (1 << ENTRY_W) - 1;
    localparam int PERCENT_SCALE = 100;

    localparam int FUNC_W  = 2;
    localparam int SIZE_W  = 17;
    localparam int STS_W   = 2;
    localparam int OFFS_W  = 16;
    localparam int PCT_W   = 7;

    // counts up to MAP_ENTRIES inclusive
    localparam int CNT_W   = $clog2(MAP_ENTRIES + 1);
    // blocks needed by the largest request
    localparam int NEED_W  =
        $clog2(((1 << SIZE_W) - 1 + BLOCK_BYTES - 1) / BLOCK_BYTES + 1);
    localparam int POOL_BYTES = MAP_ENTRIES * BLOCK_BYTES;

    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd0;
    localparam logic [FUNC_W-1:0] FN_FREE  = 2'd1;
    localparam logic [FUNC_W-1:0] FN_USAGE = 2'd2;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd3;

    localparam logic [STS_W-1:0] STS_OK    = 2'd0;
    localparam logic [STS_W-1:0] STS_ZERO  = 2'd1;
    localparam logic [STS_W-1:0] STS_NOFIT = 2'd2;
    localparam logic [STS_W-1:0] STS_RANGE = 2'd3;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [SIZE_W-1:0] req_size;
        logic [SIZE_W-1:0] free_offset;
    } t_req;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [OFFS_W-1:0] alloc_offset;
        logic [PCT_W-1:0]  usage_percent;
    } t_rsp;

endpackage

[sv/block_map_allocator_top.sv]
// ----------------------------------------------------------------------------
// block_map_allocator_top
// First-fit block allocator; the block map lives in one synchronous RAM.
// ----------------------------------------------------------------------------
//  channel   | handshake          | payload
//  ----------+--------------------+--------------------------------------
//  request   | start / busy       | i_req  (func, req_size, free_offset)
//  response  | o_done (1 cycle)   | o_rsp  (status, alloc_offset, usage)
//
//  Reset runs a clearing sweep over the map; busy is high throughout it.
//  Allocate: a scan of the map, then one write per block marked.
//  Free: a read of the head entry, then one write per entry cleared. Usage: a read of every entry.
//  Clear: a write of every entry. Zero size, oversize and range errors: no map access.
//  Every map access uses the single map RAM port, one entry per cycle.
//  The response cannot be stalled; it is valid only in the o_done cycle.
// ----------------------------------------------------------------------------
module block_map_allocator_top
    import bma_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_done,
    output t_rsp o_rsp
);

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INIT     = 4'd1;
    localparam logic [3:0] S_SCAN     = 4'd2;
    localparam logic [3:0] S_MARK     = 4'd3;
    localparam logic [3:0] S_FREE_RD  = 4'd4;
    localparam logic [3:0] S_FREE_CNT = 4'd5;
    localparam logic [3:0] S_FREE_CLR = 4'd6;
    localparam logic [3:0] S_USAGE    = 4'd7;

    localparam logic [MAP_AW-1:0] ADDR_LAST = MAP_AW'(MAP_ENTRIES - 1);
    localparam int PROD_W = CNT_W + $clog2(PERCENT_SCALE + 1);

    logic [ENTRY_W-1:0] r_map [MAP_ENTRIES];

    logic [3:0]         r_state,  n_state;
    logic [MAP_AW-1:0]  r_addr,   n_addr;
    logic               r_issue,  n_issue;
    logic               r_rd_vld, n_rd_vld;
    logic [MAP_AW-1:0]  r_rd_pos;
    logic [ENTRY_W-1:0] r_rd_data;
    logic [CNT_W-1:0]   r_run,    n_run;
    logic [NEED_W-1:0]  r_need,   n_need;
    logic [MAP_AW-1:0]  r_pos,    n_pos;
    logic [ENTRY_W-1:0] r_left,   n_left;
    logic               r_report, n_report;
    logic               r_done,   n_done;
    t_rsp               r_rsp,    n_rsp;

    logic                     w_we;
    logic [ENTRY_W-1:0]       w_wdata;
    logic [SIZE_W:0]          w_size_sum;
    logic [NEED_W-1:0]        w_need;
    logic [CNT_W-1:0]         w_run_nx;
    logic [CNT_W-1:0]         w_used;
    logic [PROD_W-1:0]        w_prod;
    logic [ENTRY_W-1:0]       w_mark;
    logic [MAP_AW+BLOCK_SHIFT-1:0] w_pos_bytes;

    assign busy   = (r_state != S_IDLE);
    assign o_done = r_done;
    assign o_rsp  = r_rsp;

    assign w_size_sum  = {1'b0, i_req.req_size} + (SIZE_W+1)'(BLOCK_BYTES - 1);
    assign w_need      = NEED_W'(w_size_sum >> BLOCK_SHIFT);
    assign w_run_nx    = (r_rd_data == '0) ? r_run + 1'b1 : '0;
    assign w_used      = r_run + CNT_W'(r_rd_data != '0);
    assign w_prod      = PROD_W'(w_used) * PROD_W'(PERCENT_SCALE);
    assign w_mark      = (r_need > NEED_W'(ENTRY_MAX)) ? ENTRY_W'(ENTRY_MAX)
                                                       : ENTRY_W'(r_need);
    assign w_pos_bytes = {r_pos, {BLOCK_SHIFT{1'b0}}};

    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_issue  = r_issue;
        n_rd_vld = 1'b0;
        n_run    = r_run;
        n_need   = r_need;
        n_pos    = r_pos;
        n_left   = r_left;
        n_report = r_report;
        n_done   = 1'b0;
        n_rsp    = r_rsp;
        w_we     = 1'b0;
        w_wdata  = '0;

        case (r_state)
            S_IDLE: begin
                if (start) begin
                    case (i_req.func)
                        FN_ALLOC: begin
                            if (i_req.req_size == '0) begin
                                n_done = 1'b1;
                                n_rsp  = '{status: STS_ZERO, alloc_offset: '0,
                                           usage_percent: '0};
                            end else if (w_need > NEED_W'(MAP_ENTRIES)) begin
                                n_done = 1'b1;
                                n_rsp  = '{status: STS_NOFIT, alloc_offset: '0,
                                           usage_percent: '0};
                            end else begin
                                n_need  = w_need;
                                n_run   = '0;
                                n_addr  = ADDR_LAST;
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        FN_FREE: begin
                            if ({1'b0, i_req.free_offset} >= (SIZE_W+1)'(POOL_BYTES)) begin
                                n_done = 1'b1;
                                n_rsp  = '{status: STS_RANGE, alloc_offset: '0,
                                           usage_percent: '0};
                            end else begin
                                n_addr  = MAP_AW'(i_req.free_offset >> BLOCK_SHIFT);
                                n_state = S_FREE_RD;
                            end
                        end
                        FN_USAGE: begin
                            n_addr  = '0;
                            n_issue = 1'b1;
                            n_run   = '0;
                            n_state = S_USAGE;
                        end
                        default: begin
                            n_addr   = '0;
                            n_report = 1'b1;
                            n_state  = S_INIT;
                        end
                    endcase
                end
            end

            // zeroing sweep, after reset or on a clear transaction
            S_INIT: begin
                w_we   = 1'b1;
                n_addr = r_addr + 1'b1;
                if (r_addr == ADDR_LAST) begin
                    n_state  = S_IDLE;
                    n_report = 1'b0;
                    if (r_report) begin
                        n_done = 1'b1;
                        n_rsp  = '{status: STS_OK, alloc_offset: '0,
                                   usage_percent: '0};
                    end
                end
            end

            // top-down scan; reads are pipelined, data returns in the following cycle
            S_SCAN: begin
                n_rd_vld = r_issue;
                if (r_issue) begin
                    n_addr = r_addr - 1'b1;
                    if (r_addr == '0)
                        n_issue = 1'b0;
                end
                if (r_rd_vld) begin
                    if (NEED_W'(w_run_nx) == r_need) begin
                        n_pos    = r_rd_pos;
                        n_addr   = r_rd_pos;
                        n_run    = '0;
                        n_issue  = 1'b0;
                        n_rd_vld = 1'b0;
                        n_state  = S_MARK;
                    end else begin
                        n_run = w_run_nx;
                        if (r_rd_pos == '0) begin
                            n_issue  = 1'b0;
                            n_rd_vld = 1'b0;
                            n_done   = 1'b1;
                            n_rsp    = '{status: STS_NOFIT, alloc_offset: '0,
                                         usage_percent: '0};
                            n_state  = S_IDLE;
                        end
                    end
                end
            end

            S_MARK: begin
                w_we    = 1'b1;
                w_wdata = w_mark;
                n_addr  = r_addr + 1'b1;
                n_run   = r_run + 1'b1;
                if (NEED_W'(n_run) == r_need) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: STS_OK, alloc_offset: OFFS_W'(w_pos_bytes),
                                usage_percent: '0};
                    n_state = S_IDLE;
                end
            end

            S_FREE_RD: begin
                n_state = S_FREE_CNT;
            end

            S_FREE_CNT: begin
                if (r_rd_data == '0) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: STS_OK, alloc_offset: '0, usage_percent: '0};
                    n_state = S_IDLE;
                end else begin
                    n_left  = r_rd_data;
                    n_state = S_FREE_CLR;
                end
            end

            // clear the run, stopping at the map end
            S_FREE_CLR: begin
                w_we   = 1'b1;
                n_addr = r_addr + 1'b1;
                n_left = r_left - 1'b1;
                if (r_left == ENTRY_W'(1) || r_addr == ADDR_LAST) begin
                    n_done  = 1'b1;
                    n_rsp   = '{status: STS_OK, alloc_offset: '0, usage_percent: '0};
                    n_state = S_IDLE;
                end
            end

            S_USAGE: begin
                n_rd_vld = r_issue;
                if (r_issue) begin
                    n_addr = r_addr + 1'b1;
                    if (r_addr == ADDR_LAST)
                        n_issue = 1'b0;
                end
                if (r_rd_vld) begin
                    n_run = w_used;
                    if (r_rd_pos == ADDR_LAST) begin
                        n_done  = 1'b1;
                        n_rsp   = '{status: STS_OK, alloc_offset: '0,
                                    usage_percent: PCT_W'(w_prod / MAP_ENTRIES)};
                        n_state = S_IDLE;
                    end
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // map RAM: one write and one registered read per cycle, same address
    always_ff @(posedge i_clk) begin
        if (w_we)
            r_map[r_addr] <= w_wdata;
        r_rd_data <= r_map[r_addr];
        r_rd_pos  <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_addr   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_report <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_addr   <= n_addr;
            r_issue  <= n_issue;
            r_rd_vld <= n_rd_vld;
            r_report <= n_report;
            r_done   <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_run  <= n_run;
        r_need <= n_need;
        r_pos  <= n_pos;
        r_left <= n_left;
        r_rsp  <= n_rsp;
    end

`ifndef ASSERT_OFF
    a_done_has_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> ($past(r_state) != S_IDLE || $past(start && !busy)))
        else $error("response without a transaction in progress");

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted transaction dropped");

    a_write_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> busy)
        else $error("map write while idle");

    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_MARK) |-> (NEED_W'(r_run) < r_need))
        else $error("run count passed request length");

    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_rsp.status != STS_OK) |->
            (o_rsp.alloc_offset == '0 && o_rsp.usage_percent == '0))
        else $error("error response carries data");
`endif

endmodule
